// ===== design/pres24_pkg.sv =====
// ----------------------------------------------------------------------------
// pres24_pkg: shared types and round helpers for the PRESENT-24 decryptor
// Holds the block width, the subkey count, the inverse S-box and permutation
// tables, and the control bundle that steers the subkey cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pres24_pkg;

  localparam int unsigned NUM_SUBKEYS = 11;
  localparam int unsigned BlockW      = 24;
  localparam int unsigned NibbleN     = BlockW / 4;
  localparam int unsigned CntW        = $clog2(NUM_SUBKEYS);

  typedef logic [BlockW-1:0] block_t;

  typedef logic [3:0] inv_sbox_t [16];
  localparam inv_sbox_t INV_SBOX = '{
    4'd5, 4'd14, 4'd15, 4'd8, 4'd12, 4'd1, 4'd2, 4'd13,
    4'd11, 4'd4, 4'd6, 4'd3, 4'd0, 4'd7, 4'd9, 4'd10
  };

  typedef logic [4:0] inv_perm_t [BlockW];
  localparam inv_perm_t INV_PERM = '{
    5'd0, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20, 5'd1, 5'd5, 5'd9, 5'd13, 5'd17, 5'd21,
    5'd2, 5'd6, 5'd10, 5'd14, 5'd18, 5'd22, 5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd23
  };

  // Steering for one subkey cell: rotate the ring or take a new subkey.
  typedef struct packed {
    logic shift;
    logic wr;
  } key_ctrl_t;

  function automatic block_t permute_back(block_t x);
    block_t y;
    y = '0;
    for (int b = 0; b < BlockW; b++) begin
      y[INV_PERM[b]] = x[b];
    end
    return y;
  endfunction

  function automatic block_t unsubstitute(block_t x);
    block_t y;
    y = '0;
    for (int n = 0; n < NibbleN; n++) begin
      y[4*n +: 4] = INV_SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

endpackage

// ===== design/pres24_key_cell.sv =====
// ----------------------------------------------------------------------------
// pres24_key_cell: one subkey slot of the rotating key ring
// Holds one 24-bit subkey. A load writes it directly; during a decrypt the
// cell takes the subkey of its lower neighbor (cell 0 that of the top cell) each cycle that shift is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pres24_key_cell (
  input  logic                clk_i,
  input  pres24_pkg::key_ctrl_t ctrl_i,
  input  pres24_pkg::block_t  wr_data_i,
  input  pres24_pkg::block_t  prev_i,
  output pres24_pkg::block_t  key_o
);

  pres24_pkg::block_t key_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.wr) begin
      key_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      key_q <= prev_i;
    end else begin
      key_q <= key_q;
    end
  end

  assign key_o = key_q;

endmodule

// ===== design/pres24_round.sv =====
// ----------------------------------------------------------------------------
// pres24_round: one inverse PRESENT-24 round
// Inverse bit permutation, inverse S-box on all six nibbles, then the XOR
// with the round subkey.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pres24_round (
  input  pres24_pkg::block_t state_i,
  input  pres24_pkg::block_t key_i,
  output pres24_pkg::block_t state_o
);

  assign state_o = pres24_pkg::unsubstitute(pres24_pkg::permute_back(state_i)) ^ key_i;

endmodule

// ===== design/present24_block_decrypt_unit.sv =====
// ----------------------------------------------------------------------------
// present24_block_decrypt_unit: PRESENT-24 block decryption with subkey ring
// A decrypt beat shows its plaintext once all of its rounds are done, and a new
// decrypt is taken only after the previous one has left the round unit: the
// single round unit fed by the rotating subkey ring works on one block at a time.
// A stalled plaintext holds the final round. A load writes its subkey cell directly.
// Reset clears control state only; subkeys are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module present24_block_decrypt_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      in_func_i,
  input  logic [3:0]                in_key_index_i,
  input  logic [pres24_pkg::BlockW-1:0] in_data_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pres24_pkg::BlockW-1:0] out_plaintext_o
);

  localparam int unsigned HeadIdx = pres24_pkg::NUM_SUBKEYS - 1;

  logic                          busy_q, busy_d;
  logic [pres24_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  pres24_pkg::block_t            st_q, st_d;
  pres24_pkg::block_t            out_q, out_d;
  pres24_pkg::block_t            round_out;
  pres24_pkg::block_t            keys [pres24_pkg::NUM_SUBKEYS];

  logic accept, start, last, advance;

  assign accept  = in_valid_i && !busy_q;
  assign start   = accept && in_func_i;
  assign last    = (cnt_q == '0);
  // The final round waits while the previous plaintext is still stalled.
  assign advance = busy_q && !(last && out_valid_q && out_stall_i);

  // Subkey ring: the head cell always holds the subkey for the current step.
  for (genvar k = 0; k < pres24_pkg::NUM_SUBKEYS; k++) begin : g_cell
    pres24_pkg::key_ctrl_t ctrl;
    pres24_pkg::block_t    prev;

    assign ctrl.shift = start || advance;
    assign ctrl.wr    = accept && !in_func_i && (32'(in_key_index_i) == k);
    if (k == 0) begin : g_wrap
      assign prev = keys[HeadIdx];
    end else begin : g_link
      assign prev = keys[k-1];
    end

    pres24_key_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_data_i (in_data_word_i),
      .prev_i    (prev),
      .key_o     (keys[k])
    );
  end

  pres24_round u_round (
    .state_i (st_q),
    .key_i   (keys[HeadIdx]),
    .state_o (round_out)
  );

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (start) begin
      busy_d = 1'b1;
      cnt_d  = pres24_pkg::CntW'(pres24_pkg::NUM_SUBKEYS - 2);
      st_d   = in_data_word_i ^ keys[HeadIdx];
    end else if (advance) begin
      st_d = round_out;
      if (last) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
        out_d       = round_out;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    out_q <= out_d;
  end

  assign in_stall_o      = busy_q;
  assign out_valid_o     = out_valid_q;
  assign out_plaintext_o = out_q;

endmodule
